[design/session_table_mark_sweep_top_macros.svh]
// ---------------------------------------------------------------------------
// Session table assertion macros
// Shared concurrent assertion forms, clocked on aclk, quiet during reset.
// ---------------------------------------------------------------------------
`ifndef SESSION_TABLE_MARK_SWEEP_TOP_MACROS_SVH
`define SESSION_TABLE_MARK_SWEEP_TOP_MACROS_SVH

// Same-cycle implication
`define STMS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define STMS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/stms_pkg.sv]
// ---------------------------------------------------------------------------
// Session table package
// Sizes, codes and the structs passed between the controller and the cells.
// ---------------------------------------------------------------------------
package stms_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam int CMD_W  = 3;
    localparam int KEY_W  = 32;
    localparam int MAC_W  = 48;
    localparam int RC_W   = 2;
    localparam int SLOT_W = 6;

    localparam int IN_BITS    = CMD_W + KEY_W + MAC_W;
    localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = RC_W + SLOT_W + 1 + MAC_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - OUT_BITS;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [SLOT_W-1:0] slot_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_FIND        = 3'd0,
        CMD_ADD         = 3'd1,
        CMD_REMOVE      = 3'd2,
        CMD_CLEAR_MARKS = 3'd3,
        CMD_MARK        = 3'd4,
        CMD_SWEEP       = 3'd5
    } cmd_t;

    typedef enum logic [RC_W-1:0] {
        RC_OK        = 2'd0,
        RC_NOT_FOUND = 2'd1,
        RC_FULL      = 2'd2
    } rc_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    // Command broadcast to every cell while a scan runs
    typedef struct packed {
        cmd_t             cmd;
        logic [KEY_W-1:0] key;
    } bcast_t;

    // Slot write at the end of an add
    typedef struct packed {
        logic             wr_en;
        idx_t             wr_slot;
        logic [KEY_W-1:0] wr_key;
        logic [MAC_W-1:0] wr_mac;
    } write_t;

    // Scan token handed from cell to cell
    typedef struct packed {
        logic             active;
        logic             found;
        idx_t             hit_slot;
        logic [MAC_W-1:0] hit_mac;
        logic             free_found;
        idx_t             free_slot;
    } token_t;

endpackage

[design/session_table_mark_sweep_top.sv]
// ---------------------------------------------------------------------------
// Session table with mark-and-sweep aging
// Associative table of IPv4 keys and MACs built as a row of slot cells.
// ---------------------------------------------------------------------------
// Each command word is taken only when the block is idle. A start register launches
// the scan token, which walks the cell row from slot 0 upward through each cell's
// token register; the scan result is then held in the result registers and loaded
// into the output register once that register is free. The next command is taken
// as soon as the result has moved into the output register, so a result may wait
// on m_tready while the next scan runs. Valid and visited bits clear at reset with
// no clearing pass; keys and MACs are only read from valid slots. An add that
// creates an entry writes the lowest free slot at the end of its scan.
`include "session_table_mark_sweep_top_macros.svh"

module session_table_mark_sweep_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    // s_tdata: command[2:0], ip_key[34:3], mac_addr[82:35], zero pad
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [stms_pkg::IN_DATA_W-1:0]  s_tdata,
    // m_tdata: result_code[1:0], slot_index[7:2], already_present[8],
    //          mac_out[56:9], zero pad
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [stms_pkg::OUT_DATA_W-1:0] m_tdata
);

    stms_pkg::bcast_t              bcast;
    stms_pkg::write_t              wr;
    stms_pkg::token_t              tok_chain [stms_pkg::TABLE_DEPTH+1];
    logic [stms_pkg::TABLE_DEPTH-1:0] active_vec;

    // Controller
    stms_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .bcast     (bcast),
        .wr        (wr),
        .start_tok (tok_chain[0]),
        .last_tok  (tok_chain[stms_pkg::TABLE_DEPTH])
    );

    // Row of slot cells, token passed from each to the next
    for (genvar i = 0; i < stms_pkg::TABLE_DEPTH; i++) begin : g_cell
        stms_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cell_index (stms_pkg::idx_t'(i)),
            .bcast      (bcast),
            .wr         (wr),
            .tok_in     (tok_chain[i]),
            .tok_out    (tok_chain[i+1])
        );
        assign active_vec[i] = tok_chain[i+1].active;
    end

    `STMS_ASSERT_IMP(a_one_token, 1'b1, $onehot0(active_vec), "more than one scan token in the row")
    `STMS_ASSERT_IMP(a_idle_row, s_tready, active_vec == '0, "ready while a scan is running")
    `STMS_ASSERT_IMP(a_write_at_end, wr.wr_en, tok_chain[stms_pkg::TABLE_DEPTH].active, "slot write outside scan end")
    `STMS_ASSERT_NXT(a_launch, s_tvalid && s_tready, tok_chain[0].active, "accepted command launched no token")

endmodule

[design/stms_cell.sv]
// ---------------------------------------------------------------------------
// Session table cell
// One slot: key, MAC, valid and visited bits, plus one stage of the scan token.
// ---------------------------------------------------------------------------
module stms_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  stms_pkg::idx_t    cell_index,
    input  stms_pkg::bcast_t  bcast,
    input  stms_pkg::write_t  wr,
    input  stms_pkg::token_t  tok_in,
    output stms_pkg::token_t  tok_out
);

    logic                       valid_reg, valid_next;
    logic                       visited_reg, visited_next;
    logic [stms_pkg::KEY_W-1:0] key_reg, key_next;
    logic [stms_pkg::MAC_W-1:0] mac_reg, mac_next;
    stms_pkg::token_t           tok_reg, tok_next;
    logic                       lookup_cmd;
    logic                       hit;
    logic                       wr_here;

    // Classify the broadcast command and test this slot
    always_comb begin
        case (bcast.cmd)
            stms_pkg::CMD_FIND,
            stms_pkg::CMD_ADD,
            stms_pkg::CMD_REMOVE,
            stms_pkg::CMD_MARK: lookup_cmd = 1'b1;
            default:            lookup_cmd = 1'b0;
        endcase
        hit     = tok_in.active && lookup_cmd && valid_reg &&
                  (key_reg == bcast.key) && !tok_in.found;
        wr_here = wr.wr_en && (wr.wr_slot == cell_index);
    end

    // Update the token as it passes: first hit and first free slot
    always_comb begin
        tok_next = tok_in;
        if (hit) begin
            tok_next.found    = 1'b1;
            tok_next.hit_slot = cell_index;
            tok_next.hit_mac  = mac_reg;
        end
        if (tok_in.active && !valid_reg && !tok_in.free_found) begin
            tok_next.free_found = 1'b1;
            tok_next.free_slot  = cell_index;
        end
    end

    // Apply the command to this slot, then any end-of-add write
    always_comb begin
        valid_next   = valid_reg;
        visited_next = visited_reg;
        key_next     = key_reg;
        mac_next     = mac_reg;
        if (tok_in.active) begin
            case (bcast.cmd)
                stms_pkg::CMD_REMOVE: begin
                    if (hit) begin
                        valid_next   = 1'b0;
                        visited_next = 1'b0;
                    end
                end
                stms_pkg::CMD_MARK: begin
                    if (hit) begin
                        visited_next = 1'b1;
                    end
                end
                stms_pkg::CMD_CLEAR_MARKS: begin
                    visited_next = 1'b0;
                end
                stms_pkg::CMD_SWEEP: begin
                    if (valid_reg && !visited_reg) begin
                        valid_next   = 1'b0;
                        visited_next = 1'b0;
                    end
                end
                default: begin
                    valid_next = valid_reg;
                end
            endcase
        end
        if (wr_here) begin
            valid_next   = 1'b1;
            visited_next = 1'b0;
            key_next     = wr.wr_key;
            mac_next     = wr.wr_mac;
        end
    end

    // Control bits: cleared at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= 1'b0;
            visited_reg    <= 1'b0;
            tok_reg.active <= 1'b0;
        end else begin
            valid_reg      <= valid_next;
            visited_reg    <= visited_next;
            tok_reg.active <= tok_next.active;
        end
    end

    // Slot contents and token payload
    always_ff @(posedge aclk) begin
        key_reg            <= key_next;
        mac_reg            <= mac_next;
        tok_reg.found      <= tok_next.found;
        tok_reg.hit_slot   <= tok_next.hit_slot;
        tok_reg.hit_mac    <= tok_next.hit_mac;
        tok_reg.free_found <= tok_next.free_found;
        tok_reg.free_slot  <= tok_next.free_slot;
    end

    assign tok_out = tok_reg;

endmodule

[design/stms_ctrl.sv]
// ---------------------------------------------------------------------------
// Session table controller
// Takes command words, launches the scan token, forms and holds result words.
// ---------------------------------------------------------------------------
module stms_ctrl (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [stms_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [stms_pkg::OUT_DATA_W-1:0] m_tdata,
    output stms_pkg::bcast_t                bcast,
    output stms_pkg::write_t                wr,
    output stms_pkg::token_t                start_tok,
    input  stms_pkg::token_t                last_tok
);

    localparam int KEY_LO = stms_pkg::CMD_W;
    localparam int MAC_LO = stms_pkg::CMD_W + stms_pkg::KEY_W;

    stms_pkg::state_t                state_reg, state_next;
    stms_pkg::cmd_t                  cmd_reg;
    logic [stms_pkg::KEY_W-1:0]      key_reg;
    logic [stms_pkg::MAC_W-1:0]      mac_reg;
    logic                            start_reg;
    stms_pkg::rc_t                   rc_reg, rc_next;
    stms_pkg::slot_t                 slot_reg, slot_next;
    logic                            present_reg, present_next;
    logic [stms_pkg::MAC_W-1:0]      rmac_reg, rmac_next;
    logic                            m_tvalid_reg;
    logic [stms_pkg::OUT_DATA_W-1:0] m_tdata_reg;
    logic                            accept;
    logic                            scan_end;
    logic                            out_free;
    logic                            out_load;
    logic                            commit;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            stms_pkg::S_IDLE: if (s_tvalid) state_next = stms_pkg::S_SCAN;
            stms_pkg::S_SCAN: if (last_tok.active) state_next = stms_pkg::S_DONE;
            stms_pkg::S_DONE: if (out_free) state_next = stms_pkg::S_IDLE;
            default:          state_next = stms_pkg::S_IDLE;
        endcase
    end

    // Handshake and strobes
    always_comb begin
        s_tready = (state_reg == stms_pkg::S_IDLE);
        accept   = s_tvalid && s_tready;
        scan_end = (state_reg == stms_pkg::S_SCAN) && last_tok.active;
        out_free = !m_tvalid_reg || m_tready;
        out_load = (state_reg == stms_pkg::S_DONE) && out_free;
        commit   = scan_end && (cmd_reg == stms_pkg::CMD_ADD) &&
                   !last_tok.found && last_tok.free_found;
    end

    // Result fields from the finished token
    always_comb begin
        rc_next      = stms_pkg::RC_OK;
        slot_next    = '0;
        present_next = 1'b0;
        rmac_next    = '0;
        case (cmd_reg)
            stms_pkg::CMD_FIND,
            stms_pkg::CMD_REMOVE,
            stms_pkg::CMD_MARK: begin
                if (last_tok.found) begin
                    slot_next = stms_pkg::slot_t'(last_tok.hit_slot);
                    rmac_next = last_tok.hit_mac;
                end else begin
                    rc_next = stms_pkg::RC_NOT_FOUND;
                end
            end
            stms_pkg::CMD_ADD: begin
                if (last_tok.found) begin
                    slot_next    = stms_pkg::slot_t'(last_tok.hit_slot);
                    rmac_next    = last_tok.hit_mac;
                    present_next = 1'b1;
                end else if (last_tok.free_found) begin
                    slot_next = stms_pkg::slot_t'(last_tok.free_slot);
                    rmac_next = mac_reg;
                end else begin
                    rc_next = stms_pkg::RC_FULL;
                end
            end
            default: begin
                rc_next = stms_pkg::RC_OK;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= stms_pkg::S_IDLE;
            start_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            start_reg <= accept;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Capture the command word
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg <= stms_pkg::cmd_t'(s_tdata[stms_pkg::CMD_W-1:0]);
            key_reg <= s_tdata[KEY_LO +: stms_pkg::KEY_W];
            mac_reg <= s_tdata[MAC_LO +: stms_pkg::MAC_W];
        end
    end

    // Hold the result until the output register is free
    always_ff @(posedge aclk) begin
        if (scan_end) begin
            rc_reg      <= rc_next;
            slot_reg    <= slot_next;
            present_reg <= present_next;
            rmac_reg    <= rmac_next;
        end
        if (out_load) begin
            m_tdata_reg <= {{stms_pkg::OUT_PAD_W{1'b0}}, rmac_reg, present_reg,
                            slot_reg, rc_reg};
        end
    end

    // Drive the cell row
    always_comb begin
        bcast.cmd            = cmd_reg;
        bcast.key            = key_reg;
        wr.wr_en             = commit;
        wr.wr_slot           = last_tok.free_slot;
        wr.wr_key            = key_reg;
        wr.wr_mac            = mac_reg;
        start_tok.active     = start_reg;
        start_tok.found      = 1'b0;
        start_tok.hit_slot   = '0;
        start_tok.hit_mac    = '0;
        start_tok.free_found = 1'b0;
        start_tok.free_slot  = '0;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
